>>> sv/rspdf_pkg.sv
// ----------------------------------------------------------------------------
// rspdf_pkg
// Types, character codes and helpers shared by the serial packet deframer.
// ----------------------------------------------------------------------------
package rspdf_pkg;

    // Deframer phase, one-hot
    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_DATA = 3'b010,
        PH_SUM  = 3'b100
    } phase_t;

    // Result event codes
    typedef enum logic [2:0] {
        EV_BYTE  = 3'd0,
        EV_GOOD  = 3'd1,
        EV_BAD   = 3'd2,
        EV_FRAME = 3'd3,
        EV_RETX  = 3'd4,
        EV_ACK   = 3'd5,
        EV_INTR  = 3'd6
    } event_t;

    // Frame error causes
    typedef enum logic [1:0] {
        ERR_DOLLAR_DATA = 2'd0,
        ERR_TOO_LONG    = 2'd1,
        ERR_BAD_HEX     = 2'd2,
        ERR_DOLLAR_SUM  = 2'd3
    } err_cause_t;

    // Input beat kinds
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_SENT = 1'b1;

    // Link characters
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_CTRL_C = 8'h03;

    // One result beat
    typedef struct packed {
        event_t     event_res;
        logic [7:0] payload_byte;
        logic [7:0] payload_length;
        logic [7:0] sent_checksum;
        logic [7:0] computed_checksum;
        err_cause_t error_cause;
    } result_t;

    // Hex digit decode result
    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } hex_t;

    // Decode one ASCII hex digit (either case)
    function automatic hex_t hex_decode(input logic [7:0] c);
        hex_t h;
        logic [7:0] d;
        h = '0;
        d = '0;
        if (c >= 8'h30 && c <= 8'h39) begin
            d       = c - 8'h30;
            h.ok    = 1'b1;
            h.value = d[3:0];
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d       = c - 8'h37;
            h.ok    = 1'b1;
            h.value = d[3:0];
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d       = c - 8'h57;
            h.ok    = 1'b1;
            h.value = d[3:0];
        end
        return h;
    endfunction

endpackage

>>> sv/rsp_packet_deframer_core.sv
// ----------------------------------------------------------------------------
// rsp_packet_deframer_core
// Deframes $payload#hh packets from a debugger serial link, streams payload
// bytes out, checks the checksum and reports ack, nack, Ctrl-C and errors.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Handshake          | Payload
//  ---------+-----------+--------------------+-------------------------------
//  s_       | in        | s_valid / s_ready  | kind, rx_byte
//  m_       | out       | m_valid / m_ready  | event, byte, length, checksums,
//           |           |                    | error cause
//  cfg_     | in        | cfg_wr_en          | max_payload_len
//
//  One beat is taken per cycle while s_ready is high; its result (if any)
//  is registered onto m_. The frame state is updated in the accepting cycle.
//  A two-entry output stage (result register plus skid register) lets input
//  flow while one result waits; s_ready drops only when both are full.
//  Reset (aresetn low, synchronous) returns to idle, clears the counters and
//  sets the length limit to 255.
//
module rsp_packet_deframer_core #(
    parameter int PACKET_BUFFER = 256
) (
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,

    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_kind,
    input  logic [7:0] s_rx_byte,

    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_event_res,
    output logic [7:0] m_payload_byte,
    output logic [7:0] m_payload_length,
    output logic [7:0] m_sent_checksum,
    output logic [7:0] m_computed_checksum,
    output logic [1:0] m_error_cause
);

    localparam logic [7:0] LIMIT_CAP = 8'(PACKET_BUFFER - 1);

    // Frame state
    rspdf_pkg::phase_t phase_reg, phase_next;
    logic [7:0] byte_count_reg, byte_count_next;
    logic [7:0] running_sum_reg, running_sum_next;
    logic [3:0] high_digit_reg, high_digit_next;
    logic       digit_index_reg, digit_index_next;
    logic       ack_pending_reg, ack_pending_next;
    logic [7:0] max_len_reg;

    // Output stage
    rspdf_pkg::result_t out_reg, skid_reg;
    logic               out_valid_reg, skid_valid_reg;

    rspdf_pkg::result_t res;
    logic               res_valid;
    logic               s_fire;
    logic [7:0]         eff_limit;
    rspdf_pkg::hex_t    hex;

    assign s_ready   = !skid_valid_reg;
    assign s_fire    = s_valid && s_ready;
    assign eff_limit = (max_len_reg > LIMIT_CAP) ? LIMIT_CAP : max_len_reg;
    assign hex       = rspdf_pkg::hex_decode(s_rx_byte);

    // Per-beat frame update and result
    always_comb begin
        phase_next       = phase_reg;
        byte_count_next  = byte_count_reg;
        running_sum_next = running_sum_reg;
        high_digit_next  = high_digit_reg;
        digit_index_next = digit_index_reg;
        ack_pending_next = ack_pending_reg;
        res              = '0;
        res_valid        = 1'b0;

        if (s_kind == rspdf_pkg::KIND_SENT) begin
            ack_pending_next = 1'b1;
        end else begin
            unique case (phase_reg)
                rspdf_pkg::PH_DATA: begin
                    if (s_rx_byte == rspdf_pkg::CH_DOLLAR) begin
                        phase_next       = rspdf_pkg::PH_IDLE;
                        byte_count_next  = '0;
                        digit_index_next = 1'b0;
                        ack_pending_next = 1'b0;
                        res.event_res    = rspdf_pkg::EV_FRAME;
                        res.error_cause  = rspdf_pkg::ERR_DOLLAR_DATA;
                        res_valid        = 1'b1;
                    end else if (s_rx_byte == rspdf_pkg::CH_HASH) begin
                        phase_next       = rspdf_pkg::PH_SUM;
                        digit_index_next = 1'b0;
                    end else if (byte_count_reg >= eff_limit) begin
                        phase_next       = rspdf_pkg::PH_IDLE;
                        byte_count_next  = '0;
                        digit_index_next = 1'b0;
                        ack_pending_next = 1'b0;
                        res.event_res    = rspdf_pkg::EV_FRAME;
                        res.error_cause  = rspdf_pkg::ERR_TOO_LONG;
                        res_valid        = 1'b1;
                    end else begin
                        byte_count_next  = byte_count_reg + 8'd1;
                        running_sum_next = running_sum_reg + s_rx_byte;
                        res.event_res    = rspdf_pkg::EV_BYTE;
                        res.payload_byte = s_rx_byte;
                        res_valid        = 1'b1;
                    end
                end
                default: begin
                    if (s_rx_byte == rspdf_pkg::CH_MINUS) begin
                        if (ack_pending_reg) begin
                            res.event_res = rspdf_pkg::EV_RETX;
                            res_valid     = 1'b1;
                        end
                    end else if (s_rx_byte == rspdf_pkg::CH_PLUS) begin
                        if (ack_pending_reg) begin
                            ack_pending_next = 1'b0;
                            res.event_res    = rspdf_pkg::EV_ACK;
                            res_valid        = 1'b1;
                        end
                    end else if (s_rx_byte == rspdf_pkg::CH_DOLLAR) begin
                        if (phase_reg == rspdf_pkg::PH_SUM) begin
                            phase_next       = rspdf_pkg::PH_IDLE;
                            byte_count_next  = '0;
                            digit_index_next = 1'b0;
                            ack_pending_next = 1'b0;
                            res.event_res    = rspdf_pkg::EV_FRAME;
                            res.error_cause  = rspdf_pkg::ERR_DOLLAR_SUM;
                            res_valid        = 1'b1;
                        end else begin
                            phase_next       = rspdf_pkg::PH_DATA;
                            byte_count_next  = '0;
                            running_sum_next = '0;
                            digit_index_next = 1'b0;
                        end
                    end else if (s_rx_byte == rspdf_pkg::CH_CTRL_C) begin
                        res.event_res = rspdf_pkg::EV_INTR;
                        res_valid     = 1'b1;
                    end else if (phase_reg == rspdf_pkg::PH_SUM) begin
                        if (!hex.ok) begin
                            phase_next       = rspdf_pkg::PH_IDLE;
                            byte_count_next  = '0;
                            digit_index_next = 1'b0;
                            ack_pending_next = 1'b0;
                            res.event_res    = rspdf_pkg::EV_FRAME;
                            res.error_cause  = rspdf_pkg::ERR_BAD_HEX;
                            res_valid        = 1'b1;
                        end else if (!digit_index_reg) begin
                            high_digit_next  = hex.value;
                            digit_index_next = 1'b1;
                        end else begin
                            // Second digit: give the verdict
                            phase_next            = rspdf_pkg::PH_IDLE;
                            digit_index_next      = 1'b0;
                            res.payload_length    = byte_count_reg;
                            res.sent_checksum     = {high_digit_reg, hex.value};
                            res.computed_checksum = running_sum_reg;
                            res_valid             = 1'b1;
                            if ({high_digit_reg, hex.value} != running_sum_reg) begin
                                byte_count_next  = '0;
                                ack_pending_next = 1'b0;
                                res.event_res    = rspdf_pkg::EV_BAD;
                            end else begin
                                res.event_res = rspdf_pkg::EV_GOOD;
                            end
                        end
                    end
                end
            endcase
        end
    end

    // Hold frame state; advance on each accepted beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= rspdf_pkg::PH_IDLE;
            byte_count_reg  <= '0;
            running_sum_reg <= '0;
            high_digit_reg  <= '0;
            digit_index_reg <= 1'b0;
            ack_pending_reg <= 1'b0;
        end else if (s_fire) begin
            phase_reg       <= phase_next;
            byte_count_reg  <= byte_count_next;
            running_sum_reg <= running_sum_next;
            high_digit_reg  <= high_digit_next;
            digit_index_reg <= digit_index_next;
            ack_pending_reg <= ack_pending_next;
        end
    end

    // Length limit register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg <= 8'd255;
        end else if (cfg_wr_en) begin
            max_len_reg <= cfg_wr_data;
        end
    end

    // Output and skid valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_ready) begin
            out_valid_reg  <= skid_valid_reg || (s_fire && res_valid);
            skid_valid_reg <= 1'b0;
        end else if (s_fire && res_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Output and skid payload
    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
            end else begin
                out_reg <= res;
            end
        end else if (s_fire && res_valid) begin
            skid_reg <= res;
        end
    end

    assign m_valid             = out_valid_reg;
    assign m_event_res         = out_reg.event_res;
    assign m_payload_byte      = out_reg.payload_byte;
    assign m_payload_length    = out_reg.payload_length;
    assign m_sent_checksum     = out_reg.sent_checksum;
    assign m_computed_checksum = out_reg.computed_checksum;
    assign m_error_cause       = out_reg.error_cause;

    // Checks
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a beat while the result register is empty");

    a_digit_in_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        digit_index_reg |-> (phase_reg == rspdf_pkg::PH_SUM))
        else $error("checksum digit pending outside checksum phase");

    a_frame_clears_ack: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && res_valid && res.event_res == rspdf_pkg::EV_FRAME)
        |=> (!ack_pending_reg && phase_reg == rspdf_pkg::PH_IDLE))
        else $error("frame error did not clear ack wait and phase");

    a_no_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready && s_fire && res_valid) |=> skid_valid_reg)
        else $error("result lost while output stalled");

endmodule
